// ===== rtl/core/ceb_pkg.sv =====
`timescale 1ns / 1ps

package ceb_pkg;

  // Field widths
  localparam int TIME_BITS   = 48;
  localparam int WINDOW_BITS = 20;
  localparam int ID_BITS     = 4;
  localparam int MULT_BITS   = 8;
  localparam int COUNT_BITS  = 32;
  localparam int REASON_BITS = 2;

  // Fired map: one entry per crate/slot/channel
  localparam int FIRED_DEPTH = 4096;
  localparam int IDX_BITS    = $clog2(FIRED_DEPTH);
  // Event tag stored per fired-map entry
  localparam int TAG_BITS    = 18;

  // Multiplicities below this limit are histogrammed
  localparam int MULT_LIMIT  = 5;
  localparam int HIST_BINS   = MULT_LIMIT - 1;

  localparam logic [WINDOW_BITS-1:0] WINDOW_RESET = WINDOW_BITS'(100);

  // Operation codes
  localparam logic OP_HIT = 1'b0;
  localparam logic OP_EOS = 1'b1;

  // Close reasons
  localparam logic [REASON_BITS-1:0] REASON_WINDOW = 2'd0;
  localparam logic [REASON_BITS-1:0] REASON_DUP    = 2'd1;
  localparam logic [REASON_BITS-1:0] REASON_EOS    = 2'd2;

  typedef struct packed {
    logic                 operation;
    logic [TIME_BITS-1:0] hit_time;
    logic [ID_BITS-1:0]   crate_id;
    logic [ID_BITS-1:0]   slot_id;
    logic [ID_BITS-1:0]   channel_id;
    logic                 is_tagger;
  } hit_t;

  typedef struct packed {
    logic                   opens_event;
    logic                   closed_valid;
    logic [MULT_BITS-1:0]   closed_mult;
    logic [REASON_BITS-1:0] close_reason;
    logic                   out_of_order;
    logic                   tagger_repeat;
    logic [COUNT_BITS-1:0]  count_mult_one;
    logic [COUNT_BITS-1:0]  count_mult_two;
    logic [COUNT_BITS-1:0]  count_mult_three;
    logic [COUNT_BITS-1:0]  count_mult_four;
  } result_t;

endpackage

// ===== rtl/core/ceb_ram.sv =====
`timescale 1ns / 1ps

module ceb_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/core/coincidence_event_builder.sv =====
`timescale 1ns / 1ps

// Channel   Dir  Handshake                Payload
// in        in   in_valid_i / in_ready_o    in_data_i  (ceb_pkg::hit_t)
// out       out  out_valid_o / out_ready_i  out_data_o (ceb_pkg::result_t)
// cfg       in   cfg_we_i                 cfg_wdata_i (coincidence window, 20 bits)
//
// One beat per cycle unless the output stalls or a sweep runs; the result is registered.
// The fired map is one synchronous RAM, read at accept, written from the result stage;
// a one-entry bypass covers back-to-back hits on the same channel.
// After reset the fired map is swept with in_ready_o low. Each entry holds an event
// tag; every 2^17 - 1 or 2^17 opens a sweep of all entries retires stale tags.
// A stalled output register holds the result stage, which in turn holds the input.

module coincidence_event_builder (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  ceb_pkg::hit_t                        in_data_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output ceb_pkg::result_t                     out_data_o,
  input  logic                                 cfg_we_i,
  input  logic [ceb_pkg::WINDOW_BITS-1:0]      cfg_wdata_i
);

  import ceb_pkg::*;

  // Configuration
  logic [WINDOW_BITS-1:0] window_q;

  // Event state
  logic                   open_q, open_d;
  logic [TIME_BITS:0]     wend_q, wend_d;
  logic [TIME_BITS-1:0]   last_q, last_d;
  logic [MULT_BITS-1:0]   mult_q, mult_d;
  logic [COUNT_BITS-1:0]  cnt_q [HIST_BINS];
  logic [COUNT_BITS-1:0]  cnt_d [HIST_BINS];
  logic [TAG_BITS-1:0]    epoch_q, epoch_d, epoch_next;

  // Pipeline: result stage and output register
  logic                   s1_valid_q, s1_valid_d;
  hit_t                   s1_q;
  logic                   out_valid_q, out_valid_d;
  result_t                out_data_q, res;
  logic                   in_fire, s1_fire, out_can;

  // Fired map access
  logic [IDX_BITS-1:0]    in_idx, s1_idx;
  logic                   ram_we;
  logic [IDX_BITS-1:0]    ram_waddr, ram_raddr;
  logic [TAG_BITS-1:0]    ram_wdata, ram_rdata;
  logic [TAG_BITS-1:0]    fired_tag;
  logic                   fired;
  logic                   hit_wr;

  // Bypass of the write made in the previous cycle
  logic                   fwd_valid_q;
  logic [IDX_BITS-1:0]    fwd_idx_q;
  logic [TAG_BITS-1:0]    fwd_tag_q;

  // Tag sweep
  logic                   scrub_req_q, scrub_req_d;
  logic                   scrub_busy_q, scrub_busy_d;
  logic [IDX_BITS-1:0]    scrub_addr_q, scrub_addr_d;
  logic                   scrub_wr_valid_q;
  logic [IDX_BITS-1:0]    scrub_wr_addr_q;
  logic [TAG_BITS-1:0]    scrub_wdata;
  logic                   scrub_start;

  // Hit decode
  logic [TIME_BITS:0]     wend_sum;
  logic                   do_close, do_open, do_join;
  logic [REASON_BITS-1:0] reason;

  assign in_idx = {in_data_i.crate_id, in_data_i.slot_id, in_data_i.channel_id};
  assign s1_idx = {s1_q.crate_id, s1_q.slot_id, s1_q.channel_id};

  // Handshake: the output register frees the result stage whenever it drains
  assign out_can    = !out_valid_q || out_ready_i;
  assign s1_fire    = s1_valid_q && out_can;
  assign in_ready_o = !scrub_req_q && !scrub_busy_q && !scrub_wr_valid_q &&
                      (!s1_valid_q || out_can);
  assign in_fire    = in_valid_i && in_ready_o;

  assign s1_valid_d  = in_fire ? 1'b1 : (s1_fire ? 1'b0 : s1_valid_q);
  assign out_valid_d = s1_fire ? 1'b1 : (out_ready_i ? 1'b0 : out_valid_q);

  // Fired lookup: bypass the write that the RAM read could not see yet
  assign fired_tag = (fwd_valid_q && (fwd_idx_q == s1_idx)) ? fwd_tag_q : ram_rdata;
  assign fired     = (fired_tag == epoch_q);

  assign wend_sum   = {1'b0, s1_q.hit_time} +
                      {{(TIME_BITS + 1 - WINDOW_BITS){1'b0}}, window_q};
  // Tag zero marks a cleared entry, so skip it on wrap
  assign epoch_next = (epoch_q == '1) ? TAG_BITS'(1) : epoch_q + TAG_BITS'(1);

  // Classify the beat in the result stage
  always_comb begin
    do_close = 1'b0;
    do_open  = 1'b0;
    do_join  = 1'b0;
    hit_wr   = 1'b0;
    reason   = REASON_WINDOW;
    if (s1_fire) begin
      if (s1_q.operation == OP_EOS) begin
        if (open_q) begin
          do_close = 1'b1;
          reason   = REASON_EOS;
        end
      end else begin
        hit_wr = 1'b1;
        if (!open_q) begin
          do_open = 1'b1;
        end else if ({1'b0, s1_q.hit_time} > wend_q) begin
          do_close = 1'b1;
          do_open  = 1'b1;
          reason   = REASON_WINDOW;
        end else if (fired && !s1_q.is_tagger) begin
          do_close = 1'b1;
          do_open  = 1'b1;
          reason   = REASON_DUP;
        end else begin
          do_join = 1'b1;
        end
      end
    end
  end

  // Update event state and build the result
  always_comb begin
    open_d  = open_q;
    wend_d  = wend_q;
    last_d  = last_q;
    mult_d  = mult_q;
    epoch_d = epoch_q;
    for (int k = 0; k < HIST_BINS; k++) begin
      cnt_d[k] = cnt_q[k];
    end
    res = '0;

    if (do_close) begin
      res.closed_valid = 1'b1;
      res.closed_mult  = mult_q;
      res.close_reason = reason;
      open_d           = 1'b0;
      // Bump the histogram bin, saturating
      for (int k = 0; k < HIST_BINS; k++) begin
        if ((mult_q == MULT_BITS'(k + 1)) && (cnt_q[k] != '1)) begin
          cnt_d[k] = cnt_q[k] + COUNT_BITS'(1);
        end
      end
    end

    if (do_open) begin
      res.opens_event = 1'b1;
      open_d          = 1'b1;
      mult_d          = MULT_BITS'(1);
      last_d          = s1_q.hit_time;
      wend_d          = wend_sum;
      epoch_d         = epoch_next;
    end

    if (do_join) begin
      res.tagger_repeat = fired;
      res.out_of_order  = (s1_q.hit_time < last_q);
      if (mult_q != '1) begin
        mult_d = mult_q + MULT_BITS'(1);
      end
      last_d = s1_q.hit_time;
      wend_d = wend_sum;
    end

    res.count_mult_one   = cnt_d[0];
    res.count_mult_two   = cnt_d[1];
    res.count_mult_three = cnt_d[2];
    res.count_mult_four  = cnt_d[3];
  end

  // Sweep control: start once the result stage has drained
  assign scrub_start = scrub_req_q && !s1_valid_q;
  assign scrub_req_d = (do_open && (&epoch_next[TAG_BITS-2:0])) ? 1'b1 :
                       (scrub_start ? 1'b0 : scrub_req_q);

  always_comb begin
    scrub_busy_d = scrub_busy_q;
    scrub_addr_d = scrub_addr_q;
    if (scrub_start) begin
      scrub_busy_d = 1'b1;
      scrub_addr_d = '0;
    end else if (scrub_busy_q) begin
      scrub_addr_d = scrub_addr_q + IDX_BITS'(1);
      if (scrub_addr_q == '1) begin
        scrub_busy_d = 1'b0;
      end
    end
  end

  // Keep entries of the current event, drop everything else to tag zero
  assign scrub_wdata = ((ram_rdata == epoch_q) && (epoch_q != '0)) ? ram_rdata : '0;

  // RAM ports: sweep, stalled re-read, or fresh read at accept
  always_comb begin
    if (scrub_busy_q) begin
      ram_raddr = scrub_addr_q;
    end else if (s1_valid_q && !out_can) begin
      ram_raddr = s1_idx;
    end else begin
      ram_raddr = in_idx;
    end
    if (scrub_wr_valid_q) begin
      ram_we    = 1'b1;
      ram_waddr = scrub_wr_addr_q;
      ram_wdata = scrub_wdata;
    end else begin
      ram_we    = hit_wr;
      ram_waddr = s1_idx;
      ram_wdata = epoch_d;
    end
  end

  ceb_ram #(
    .Width (TAG_BITS),
    .Depth (FIRED_DEPTH)
  ) u_fired_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Control and state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_q         <= WINDOW_RESET;
      open_q           <= 1'b0;
      wend_q           <= '0;
      last_q           <= '0;
      mult_q           <= '0;
      epoch_q          <= '0;
      for (int k = 0; k < HIST_BINS; k++) begin
        cnt_q[k] <= '0;
      end
      s1_valid_q       <= 1'b0;
      out_valid_q      <= 1'b0;
      fwd_valid_q      <= 1'b0;
      scrub_req_q      <= 1'b0;
      scrub_busy_q     <= 1'b1;
      scrub_addr_q     <= '0;
      scrub_wr_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        window_q <= cfg_wdata_i;
      end
      open_q           <= open_d;
      wend_q           <= wend_d;
      last_q           <= last_d;
      mult_q           <= mult_d;
      epoch_q          <= epoch_d;
      for (int k = 0; k < HIST_BINS; k++) begin
        cnt_q[k] <= cnt_d[k];
      end
      s1_valid_q       <= s1_valid_d;
      out_valid_q      <= out_valid_d;
      fwd_valid_q      <= hit_wr;
      scrub_req_q      <= scrub_req_d;
      scrub_busy_q     <= scrub_busy_d;
      scrub_addr_q     <= scrub_addr_d;
      scrub_wr_valid_q <= scrub_busy_q;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_q <= in_data_i;
    end
    if (s1_fire) begin
      out_data_q <= res;
    end
    fwd_idx_q       <= s1_idx;
    fwd_tag_q       <= epoch_d;
    scrub_wr_addr_q <= scrub_addr_q;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

// ===== tb/coincidence_event_builder_test.sv =====
`timescale 1ns / 1ps

module coincidence_event_builder_test;
  import ceb_pkg::*;

  logic    clk_i;
  logic    rst_ni;
  logic    in_valid_i;
  logic    in_ready_o;
  hit_t    in_data_i;
  logic    out_valid_o;
  logic    out_ready_i;
  result_t out_data_o;
  logic    cfg_we_i;
  logic [WINDOW_BITS-1:0] cfg_wdata_i;

  coincidence_event_builder u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  // 10 ns period: low half then high half.
  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // ---------------------------------------------------------------------------
  // Event-building state as the block should hold it. Updated at each accepted
  // input beat, so every accepted beat yields exactly one expected result.
  // ---------------------------------------------------------------------------
  logic [WINDOW_BITS-1:0] window_ticks   = WINDOW_RESET;
  logic                   ev_open        = 1'b0;
  logic [TIME_BITS:0]     ev_window_end  = '0;
  logic [TIME_BITS-1:0]   ev_last_time   = '0;
  logic [MULT_BITS-1:0]   ev_mult        = '0;
  logic [FIRED_DEPTH-1:0] ev_fired       = '0;
  logic [COUNT_BITS-1:0]  mult_hist [HIST_BINS];

  result_t pending_results [$];
  int      mismatch_count = 0;
  bit      calm_phase     = 1'b0;

  // Stimulus bookkeeping: time of the stream and the ids last used.
  logic [TIME_BITS-1:0]   stream_time = '0;
  logic [3*ID_BITS-1:0]   recent_ids  = '0;

  initial begin
    for (int b = 0; b < HIST_BINS; b++) mult_hist[b] = '0;
  end

  // Work out the result of one accepted beat and advance the event state.
  function automatic result_t predict_event_result(hit_t h);
    result_t              r;
    logic [IDX_BITS-1:0]  idx;
    logic                 closing;
    logic                 opening;
    logic [REASON_BITS-1:0] reason;
    r       = '0;
    idx     = {h.crate_id, h.slot_id, h.channel_id};
    closing = 1'b0;
    opening = 1'b0;
    reason  = REASON_WINDOW;
    if (h.operation == OP_EOS) begin
      // End of stream closes whatever is open; hit fields are don't-care.
      if (ev_open) begin
        closing = 1'b1;
        reason  = REASON_EOS;
      end
    end else if (!ev_open) begin
      opening = 1'b1;
    end else if ({1'b0, h.hit_time} > ev_window_end) begin
      closing = 1'b1;
      opening = 1'b1;
      reason  = REASON_WINDOW;
    end else if (ev_fired[idx] && !h.is_tagger) begin
      closing = 1'b1;
      opening = 1'b1;
      reason  = REASON_DUP;
    end else begin
      // Join: roll the window forward from this hit.
      r.tagger_repeat = ev_fired[idx];
      r.out_of_order  = (h.hit_time < ev_last_time);
      if (ev_mult != '1) ev_mult = ev_mult + 1'b1;
      ev_fired[idx]  = 1'b1;
      ev_last_time   = h.hit_time;
      ev_window_end  = {1'b0, h.hit_time} + (TIME_BITS+1)'(window_ticks);
    end

    if (closing) begin
      r.closed_valid = 1'b1;
      r.closed_mult  = ev_mult;
      r.close_reason = reason;
      // Histogram multiplicities 1..4 only, saturating.
      if (ev_mult >= 1 && ev_mult < MULT_LIMIT && mult_hist[ev_mult-1] != '1)
        mult_hist[ev_mult-1] = mult_hist[ev_mult-1] + 1'b1;
      ev_open = 1'b0;
    end

    if (opening) begin
      r.opens_event = 1'b1;
      ev_fired      = '0;
      ev_fired[idx] = 1'b1;
      ev_mult       = MULT_BITS'(1);
      ev_last_time  = h.hit_time;
      ev_window_end = {1'b0, h.hit_time} + (TIME_BITS+1)'(window_ticks);
      ev_open       = 1'b1;
    end

    r.count_mult_one   = mult_hist[0];
    r.count_mult_two   = mult_hist[1];
    r.count_mult_three = mult_hist[2];
    r.count_mult_four  = mult_hist[3];
    return r;
  endfunction

  function automatic logic [TIME_BITS-1:0] random_ticks();
    return TIME_BITS'({$urandom(), $urandom()});
  endfunction

  function automatic hit_t make_hit(logic [TIME_BITS-1:0] t, logic [ID_BITS-1:0] crate,
                                    logic [ID_BITS-1:0] slot, logic [ID_BITS-1:0] chan,
                                    logic tagger);
    hit_t h;
    h.operation  = OP_HIT;
    h.hit_time   = t;
    h.crate_id   = crate;
    h.slot_id    = slot;
    h.channel_id = chan;
    h.is_tagger  = tagger;
    return h;
  endfunction

  // End of stream with junk in the hit fields; the block must ignore them.
  function automatic hit_t make_eos();
    hit_t h;
    h = make_hit(random_ticks(), ID_BITS'($urandom()), ID_BITS'($urandom()),
                 ID_BITS'($urandom()), 1'($urandom()));
    h.operation = OP_EOS;
    return h;
  endfunction

  // ---------------------------------------------------------------------------
  // Driving. All input changes happen at the falling edge; beats are taken
  // at the rising edge where valid and ready are both high.
  // ---------------------------------------------------------------------------
  task automatic send_beat(input hit_t h);
    if (!calm_phase && $urandom_range(0, 3) == 0) begin
      // Drop valid for a burst and scramble the idle payload.
      in_valid_i <= 1'b0;
      in_data_i  <= make_eos();
      repeat ($urandom_range(1, 16)) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= h;
    do @(posedge clk_i); while (!in_ready_o);
    pending_results.push_back(predict_event_result(h));
    @(negedge clk_i);
  endtask

  // Hold the sender off until every expected result is back, then let the
  // two-stage pipe empty out.
  task automatic settle();
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_window(input logic [WINDOW_BITS-1:0] ticks);
    settle();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= ticks;
    @(negedge clk_i);
    cfg_we_i     <= 1'b0;
    window_ticks  = ticks;
  endtask

  // Receiver: stall in random bursts, never in the calm phase.
  initial begin
    out_ready_i = 1'b1;
    forever begin
      @(negedge clk_i);
      if (!calm_phase && $urandom_range(0, 7) == 0) begin
        out_ready_i <= 1'b0;
        repeat ($urandom_range(1, 16)) @(negedge clk_i);
      end
      out_ready_i <= 1'b1;
    end
  end

  // ---------------------------------------------------------------------------
  // Checking: compare each result beat against the oldest expectation.
  // ---------------------------------------------------------------------------
  task automatic check_field(input string field, input logic [63:0] want,
                             input logic [63:0] got);
    if (want !== got) begin
      $display("%0t ns: %s expected %0d, actual %0d", $time, field, want, got);
      mismatch_count++;
    end
  endtask

  initial begin
    result_t want;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o && out_ready_i) begin
        if (pending_results.size() == 0) begin
          $display("%0t ns: result beat with nothing expected, actual %h", $time,
                   out_data_o);
          mismatch_count++;
        end else begin
          want = pending_results.pop_front();
          check_field("opens_event", want.opens_event, out_data_o.opens_event);
          check_field("closed_valid", want.closed_valid, out_data_o.closed_valid);
          check_field("closed_mult", want.closed_mult, out_data_o.closed_mult);
          check_field("close_reason", want.close_reason, out_data_o.close_reason);
          check_field("out_of_order", want.out_of_order, out_data_o.out_of_order);
          check_field("tagger_repeat", want.tagger_repeat, out_data_o.tagger_repeat);
          check_field("count_mult_one", want.count_mult_one, out_data_o.count_mult_one);
          check_field("count_mult_two", want.count_mult_two, out_data_o.count_mult_two);
          check_field("count_mult_three", want.count_mult_three,
                      out_data_o.count_mult_three);
          check_field("count_mult_four", want.count_mult_four,
                      out_data_o.count_mult_four);
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Every close reason, join flags, boundary times and time wrap at window 100.
  task automatic test_basic_events();
    write_window(WINDOW_BITS'(100));
    send_beat(make_eos());                                  // nothing open
    send_beat(make_hit(48'd1000, 4'd0, 4'd0, 4'd0, 1'b0));    // opens
    send_beat(make_hit(48'd1100, 4'd15, 4'd15, 4'd15, 1'b0)); // exactly at window end
    send_beat(make_hit(48'd1050, 4'd3, 4'd4, 4'd5, 1'b0));    // earlier than last join
    send_beat(make_hit(48'd1060, 4'd3, 4'd4, 4'd5, 1'b1));    // tagger fires again
    send_beat(make_hit(48'd1070, 4'd15, 4'd15, 4'd15, 1'b0)); // duplicate closes at 4
    send_beat(make_hit(48'd1171, 4'd1, 4'd2, 4'd3, 1'b0));    // one past window end
    send_beat(make_hit(48'd1180, 4'd0, 4'd0, 4'd1, 1'b0));
    send_beat(make_eos());                                  // closes at 2
    send_beat(make_eos());                                  // nothing left to close
    send_beat(make_hit('1, 4'd9, 4'd9, 4'd9, 1'b1));         // window end past 2^48
    send_beat(make_hit(48'd0, 4'd9, 4'd9, 4'd8, 1'b0));       // joins across the wrap
    send_beat(make_hit(48'd5, 4'd9, 4'd9, 4'd7, 1'b0));
    send_beat(make_hit(48'd106, 4'd9, 4'd9, 4'd6, 1'b0));     // closes at 3
    for (int k = 1; k <= 4; k++)
      send_beat(make_hit(48'd106 + 48'(10 * k), 4'(k), 4'd0, 4'd0, 1'b0));
    send_beat(make_eos());                                  // multiplicity 5, no count
  endtask

  // Zero-width window and the widest window, each at its boundary.
  task automatic test_window_extremes();
    write_window('0);
    send_beat(make_hit(48'd500, 4'd2, 4'd2, 4'd2, 1'b0));
    send_beat(make_hit(48'd500, 4'd2, 4'd2, 4'd3, 1'b0));     // same tick joins
    send_beat(make_hit(48'd501, 4'd2, 4'd2, 4'd4, 1'b0));     // next tick closes
    write_window('1);
    send_beat(make_hit(48'd501 + 48'hF_FFFF, 4'd5, 4'd5, 4'd5, 1'b0));
    send_beat(make_hit(48'd502 + 48'h1F_FFFE, 4'd6, 4'd6, 4'd6, 1'b0));
    send_beat(make_eos());
    stream_time = 48'd4000000;
  endtask

  // One tagger channel firing past 255 hits: multiplicity saturates.
  task automatic test_mult_saturation();
    write_window(WINDOW_BITS'(100));
    send_beat(make_eos());
    for (int k = 0; k < 262; k++) begin
      stream_time = stream_time + TIME_BITS'($urandom_range(0, 3));
      send_beat(make_hit(stream_time, 4'hA, 4'hB, 4'hC, 1'b1));
    end
    send_beat(make_eos());
  endtask

  // Mostly time-sorted traffic with random spacing and ids, plus noise:
  // random jumps anywhere in the time range, late hits and end-of-stream beats.
  task automatic random_events(input int count);
    int   pick;
    logic tagger;
    for (int k = 0; k < count; k++) begin
      pick = $urandom_range(0, 99);
      if (pick < 5) begin
        send_beat(make_eos());
      end else begin
        if (pick < 12)
          stream_time = random_ticks();
        else if (pick < 20)
          stream_time = stream_time + window_ticks + 1 + $urandom_range(0, 500);
        else if (pick < 25)
          stream_time = stream_time + window_ticks;
        else if (pick < 30)
          stream_time = stream_time - $urandom_range(1, 20);
        else
          stream_time = stream_time + $urandom_range(0, window_ticks >> 2);
        // Reuse ids often enough that duplicates and tagger repeats happen.
        if ($urandom_range(0, 3) != 0) recent_ids = 12'($urandom());
        tagger = ($urandom_range(0, 4) == 0);
        send_beat(make_hit(stream_time, recent_ids[11:8], recent_ids[7:4],
                           recent_ids[3:0], tagger));
      end
    end
  endtask

  task automatic test_random_traffic();
    random_events(50);
    settle();
    random_events(50);
    write_window('0);
    random_events(75);
    write_window(WINDOW_BITS'(1));
    random_events(75);
    write_window('1);
    random_events(75);
    write_window(WINDOW_BITS'($urandom_range(0, 1048575)));
    random_events(75);
    write_window(WINDOW_BITS'($urandom_range(2, 5000)));
    random_events(75);
  endtask

  // Back-to-back beats with no stalls on either side.
  task automatic test_steady_stream();
    write_window(WINDOW_BITS'(100));
    calm_phase = 1'b1;
    random_events(80);
  endtask

  initial begin
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    in_data_i   = '0;
    cfg_we_i    = 1'b0;
    cfg_wdata_i = '0;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_basic_events();
    test_window_extremes();
    test_mult_saturation();
    test_random_traffic();
    test_steady_stream();

    settle();
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run including the fired-map sweep.
  initial begin
    #5ms;
    $display("end of test: mismatches");
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/core/ceb_pkg.sv
rtl/core/ceb_ram.sv
rtl/core/coincidence_event_builder.sv
tb/coincidence_event_builder_test.sv
